// ===== rtl/cde_pkg.sv =====
// Shared types and constants for the color distance edge block.
package cde_pkg;

  parameter int MAX_WIDTH  = 2048;
  parameter int MAX_HEIGHT = 4096;
  parameter int COL_W      = $clog2(MAX_WIDTH);
  parameter int ROW_W      = $clog2(MAX_HEIGHT);
  parameter int WID_W      = COL_W + 1;
  parameter int HGT_W      = ROW_W + 1;
  parameter int THR_W      = 9;
  parameter int THR2_W     = 2 * THR_W;
  parameter int SIZE_MIN   = 3;
  parameter int MARK_MIN   = 3;
  parameter int NUM_NBR    = 8;

  parameter logic [1:0] REG_THRESH = 2'd0;
  parameter logic [1:0] REG_MONO   = 2'd1;
  parameter logic [1:0] REG_WIDTH  = 2'd2;
  parameter logic [1:0] REG_HEIGHT = 2'd3;

  typedef struct packed {
    logic [7:0] pix_alpha;
    logic [7:0] pix_red;
    logic [7:0] pix_green;
    logic [7:0] pix_blue;
  } pix_t;

  typedef struct packed {
    pix_t older;
    pix_t prev;
  } line_t;

  typedef struct packed {
    logic [COL_W-1:0] center_col;
    logic [ROW_W-1:0] center_row;
    logic             is_marked;
    logic [7:0]       out_alpha;
    logic [7:0]       out_red;
    logic [7:0]       out_green;
    logic [7:0]       out_blue;
    logic             frame_done;
  } res_t;

endpackage

// ===== rtl/cde_line_mem.sv =====
// Two-row line store: one word per column holds the two rows above the current one.
module cde_line_mem (
  input  logic                      clk,
  input  logic                      rd_en,
  input  logic [cde_pkg::COL_W-1:0] rd_addr,
  output cde_pkg::line_t            rd_data,
  input  logic                      wr_en,
  input  logic [cde_pkg::COL_W-1:0] wr_addr,
  input  cde_pkg::line_t            wr_data
);

  cde_pkg::line_t mem [cde_pkg::MAX_WIDTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/cde_dist.sv =====
// Eight squared RGB distance units and the differing-neighbor count.
module cde_dist (
  input  cde_pkg::pix_t              center,
  input  cde_pkg::pix_t              nbr [cde_pkg::NUM_NBR],
  input  logic [cde_pkg::THR2_W-1:0] thr2,
  output logic                       marked
);

  function automatic logic [15:0] sq_diff(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] d;
    d = (a >= b) ? (a - b) : (b - a);
    return {8'd0, d} * {8'd0, d};
  endfunction

  logic [cde_pkg::NUM_NBR-1:0] differs;
  logic [cde_pkg::THR2_W-1:0]  dist2 [cde_pkg::NUM_NBR];

  always_comb begin
    for (int k = 0; k < cde_pkg::NUM_NBR; k++) begin
      dist2[k] = cde_pkg::THR2_W'(sq_diff(nbr[k].pix_red, center.pix_red))
               + cde_pkg::THR2_W'(sq_diff(nbr[k].pix_green, center.pix_green))
               + cde_pkg::THR2_W'(sq_diff(nbr[k].pix_blue, center.pix_blue));
      differs[k] = (dist2[k] >= thr2);
    end
  end

  assign marked = ($countones(differs) >= cde_pkg::MARK_MIN);

endmodule

// ===== rtl/color_distance_edge_sketch_top.sv =====
// Top level of the color distance edge block: counters, window, config and handshakes.
//
// Pixels enter in raster order on the in_ channel (valid/stall), one per request.
// For every interior pixel (not on the first or last row or column) one result
// leaves on the out_ channel: its position, the mark flag, the output ARGB value
// and a frame_done flag on the last interior pixel. Border pixels give no result.
// An accepted request issues the line store read and loads the stage 1 registers;
// the window, distance units and count work from those and the read data, and
// load the result register when stage 1 advances.
// One pixel per cycle is sustained while out_stall stays low; the single-port-read
// line store and the output register set it.
// When out_stall holds a result, the stage behind it holds too and in_stall rises
// the same cycle; a pixel that gives no result still drains.
// Reset clears the counters and the registers (threshold 0, color mode, 640x480);
// the line stores need no clearing, since the first two rows and columns of a
// frame fill them before any read that feeds a result. A write to image_width or
// image_height restarts the frame. Registers lie at byte addresses 0, 4, 8, 12.
module color_distance_edge_sketch_top (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  cde_pkg::pix_t in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output cde_pkg::res_t out_data,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [3:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready
);

  localparam int COL_W  = cde_pkg::COL_W;
  localparam int ROW_W  = cde_pkg::ROW_W;
  localparam int WID_W  = cde_pkg::WID_W;
  localparam int HGT_W  = cde_pkg::HGT_W;
  localparam int THR_W  = cde_pkg::THR_W;
  localparam int THR2_W = cde_pkg::THR2_W;

  localparam logic [WID_W-1:0] W_MIN = WID_W'(cde_pkg::SIZE_MIN);
  localparam logic [WID_W-1:0] W_MAX = WID_W'(cde_pkg::MAX_WIDTH);
  localparam logic [HGT_W-1:0] H_MIN = HGT_W'(cde_pkg::SIZE_MIN);
  localparam logic [HGT_W-1:0] H_MAX = HGT_W'(cde_pkg::MAX_HEIGHT);

  localparam cde_pkg::pix_t PIX_WHITE = 32'hFFFF_FFFF;
  localparam cde_pkg::pix_t PIX_BLACK = 32'hFF00_0000;

  // configuration
  logic [THR_W-1:0]  thresh_r;
  logic [THR2_W-1:0] thr2_r;
  logic              mono_r;
  logic [WID_W-1:0]  width_r;
  logic [HGT_W-1:0]  height_r;
  logic              cfg_wr;
  logic [1:0]        cfg_idx;
  logic [THR2_W-1:0] thr2_nxt;

  assign pready  = 1'b1;
  assign cfg_idx = paddr[3:2];
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign thr2_nxt = THR2_W'(pwdata[THR_W-1:0]) * THR2_W'(pwdata[THR_W-1:0]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thresh_r <= '0;
      thr2_r   <= '0;
      mono_r   <= 1'b0;
      width_r  <= WID_W'(640);
      height_r <= HGT_W'(480);
    end else if (cfg_wr) begin
      case (cfg_idx)
        cde_pkg::REG_THRESH: begin
          thresh_r <= pwdata[THR_W-1:0];
          thr2_r   <= thr2_nxt;
        end
        cde_pkg::REG_MONO:   mono_r   <= pwdata[0];
        cde_pkg::REG_WIDTH:  width_r  <= pwdata[WID_W-1:0];
        cde_pkg::REG_HEIGHT: height_r <= pwdata[HGT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      cde_pkg::REG_THRESH: prdata = 32'(thresh_r);
      cde_pkg::REG_MONO:   prdata = 32'(mono_r);
      cde_pkg::REG_WIDTH:  prdata = 32'(width_r);
      cde_pkg::REG_HEIGHT: prdata = 32'(height_r);
      default:             prdata = '0;
    endcase
  end

  // frame geometry and position counters
  logic [WID_W-1:0] w_cl;
  logic [HGT_W-1:0] h_cl;
  logic [COL_W-1:0] col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic             last_col, last_row, in_prod, in_acc, size_wr;

  assign w_cl = (width_r < W_MIN) ? W_MIN : ((width_r > W_MAX) ? W_MAX : width_r);
  assign h_cl = (height_r < H_MIN) ? H_MIN : ((height_r > H_MAX) ? H_MAX : height_r);

  assign last_col = (({1'b0, col_r} + WID_W'(1)) == w_cl);
  assign last_row = (({1'b0, row_r} + HGT_W'(1)) == h_cl);
  assign in_prod  = (col_r >= COL_W'(2)) && (row_r >= ROW_W'(2));
  assign size_wr  = cfg_wr && ((cfg_idx == cde_pkg::REG_WIDTH) ||
                               (cfg_idx == cde_pkg::REG_HEIGHT));

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (size_wr) begin
      col_nxt = '0;
      row_nxt = '0;
    end else if (in_acc) begin
      if (last_col) begin
        col_nxt = '0;
        row_nxt = last_row ? '0 : (row_r + ROW_W'(1));
      end else begin
        col_nxt = col_r + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // stage 1: line store read data and window
  logic             s1_valid_r, s1_prod_r, s1_done_r;
  cde_pkg::pix_t    s1_pix_r;
  logic [COL_W-1:0] s1_col_r;
  logic [ROW_W-1:0] s1_row_r;
  logic             s1_adv, out_free;
  cde_pkg::line_t   rd_data, wr_data;
  cde_pkg::pix_t    win_r [6];
  cde_pkg::pix_t    nbr [cde_pkg::NUM_NBR];
  logic             marked;

  assign out_free = !out_valid || !out_stall;
  assign s1_adv   = s1_valid_r && (!s1_prod_r || out_free);
  assign in_stall = s1_valid_r && !s1_adv;
  assign in_acc   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_acc) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_pix_r  <= in_data;
      s1_col_r  <= col_r;
      s1_row_r  <= row_r;
      s1_prod_r <= in_prod;
      s1_done_r <= last_col && last_row;
    end
  end

  assign wr_data.older = rd_data.prev;
  assign wr_data.prev  = s1_pix_r;

  cde_line_mem u_line_mem (
    .clk     (clk),
    .rd_en   (in_acc),
    .rd_addr (col_r),
    .rd_data (rd_data),
    .wr_en   (s1_adv),
    .wr_addr (s1_col_r),
    .wr_data (wr_data)
  );

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      win_r[0] <= win_r[3];
      win_r[1] <= win_r[4];
      win_r[2] <= win_r[5];
      win_r[3] <= rd_data.older;
      win_r[4] <= rd_data.prev;
      win_r[5] <= s1_pix_r;
    end
  end

  assign nbr[0] = win_r[0];
  assign nbr[1] = win_r[1];
  assign nbr[2] = win_r[2];
  assign nbr[3] = win_r[3];
  assign nbr[4] = win_r[5];
  assign nbr[5] = rd_data.older;
  assign nbr[6] = rd_data.prev;
  assign nbr[7] = s1_pix_r;

  cde_dist u_dist (
    .center (win_r[4]),
    .nbr    (nbr),
    .thr2   (thr2_r),
    .marked (marked)
  );

  // result register
  logic          out_valid_r;
  cde_pkg::res_t out_data_r, res_nxt;
  cde_pkg::pix_t res_pix;

  assign res_pix = !marked ? PIX_WHITE : (mono_r ? PIX_BLACK : win_r[4]);

  always_comb begin
    res_nxt.center_col = s1_col_r - COL_W'(1);
    res_nxt.center_row = s1_row_r - ROW_W'(1);
    res_nxt.is_marked  = marked;
    res_nxt.out_alpha  = res_pix.pix_alpha;
    res_nxt.out_red    = res_pix.pix_red;
    res_nxt.out_green  = res_pix.pix_green;
    res_nxt.out_blue   = res_pix.pix_blue;
    res_nxt.frame_done = s1_done_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv && s1_prod_r) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_prod_r) begin
      out_data_r <= res_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r)
    else $error("input stalled with empty stage");

  a_col_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, col_r} < w_cl)
    else $error("column counter beyond frame width");

  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(s1_adv && s1_prod_r))
    else $error("result shown without an interior pixel");
`endif

endmodule

// ===== tb/sv/tb.sv =====
// Self-checking testbench for the color distance edge block: 3x3 window marks over raster frames.
`timescale 1ns / 100ps

module tb;

  localparam logic [3:0] REG_THRESHOLD = {cde_pkg::REG_THRESH, 2'b00};
  localparam logic [3:0] REG_MONO      = {cde_pkg::REG_MONO, 2'b00};
  localparam logic [3:0] REG_WIDTH     = {cde_pkg::REG_WIDTH, 2'b00};
  localparam logic [3:0] REG_HEIGHT    = {cde_pkg::REG_HEIGHT, 2'b00};

  logic          clk = 1'b0;
  logic          rst_n = 1'b0;
  logic          in_valid = 1'b0;
  logic          in_stall;
  cde_pkg::pix_t in_data = '0;
  logic          out_valid;
  logic          out_stall = 1'b0;
  cde_pkg::res_t out_data;
  logic          psel = 1'b0;
  logic          penable = 1'b0;
  logic          pwrite = 1'b0;
  logic [3:0]    paddr = '0;
  logic [31:0]   pwdata = '0;
  logic [31:0]   prdata;
  logic          pready;

  // predictor state
  cde_pkg::pix_t older_line [cde_pkg::MAX_WIDTH];
  cde_pkg::pix_t prev_line [cde_pkg::MAX_WIDTH];
  cde_pkg::pix_t win_col [6];
  int   col_pos = 0;
  int   row_pos = 0;
  int   edge_thr = 0;
  int   edge_mono = 0;
  int   frame_w = 640;
  int   frame_h = 480;

  cde_pkg::res_t expected_edges [$];
  int   mismatch_count = 0;
  int   send_idle_pct = 0;
  int   recv_idle_pct = 0;
  int   hold_left = 0;

  color_distance_edge_sketch_top u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned exp_v);
    mismatch_count++;
    if (mismatch_count <= 40) begin
      $display("mismatch %s: got 0x%0h, want 0x%0h", what, got, exp_v);
    end
  endtask

  task automatic predict_edge(input cde_pkg::pix_t p);
    cde_pkg::pix_t top_pix, mid_pix, center, shown;
    cde_pkg::pix_t nbr [cde_pkg::NUM_NBR];
    int   dr, dg, db, k, hits;
    cde_pkg::res_t r;
    top_pix = older_line[col_pos];
    mid_pix = prev_line[col_pos];
    if (row_pos >= 2 && col_pos >= 2) begin
      center = win_col[4];
      nbr = '{win_col[0], win_col[1], win_col[2], win_col[3], win_col[5], top_pix, mid_pix, p};
      hits = 0;
      for (k = 0; k < cde_pkg::NUM_NBR; k++) begin
        dr = int'(nbr[k].pix_red) - int'(center.pix_red);
        dg = int'(nbr[k].pix_green) - int'(center.pix_green);
        db = int'(nbr[k].pix_blue) - int'(center.pix_blue);
        if (dr * dr + dg * dg + db * db >= edge_thr * edge_thr) hits++;
      end
      if (hits < cde_pkg::MARK_MIN) shown = 32'hFFFF_FFFF;
      else if (edge_mono != 0) shown = 32'hFF00_0000;
      else shown = center;
      r.center_col = cde_pkg::COL_W'(col_pos - 1);
      r.center_row = cde_pkg::ROW_W'(row_pos - 1);
      r.is_marked  = (hits >= cde_pkg::MARK_MIN);
      r.out_alpha  = shown.pix_alpha;
      r.out_red    = shown.pix_red;
      r.out_green  = shown.pix_green;
      r.out_blue   = shown.pix_blue;
      r.frame_done = (col_pos + 1 >= frame_w) && (row_pos + 1 >= frame_h);
      expected_edges.push_back(r);
    end
    win_col[0] = win_col[3];
    win_col[1] = win_col[4];
    win_col[2] = win_col[5];
    win_col[3] = top_pix;
    win_col[4] = mid_pix;
    win_col[5] = p;
    older_line[col_pos] = mid_pix;
    prev_line[col_pos] = p;
    col_pos++;
    if (col_pos >= frame_w) begin
      col_pos = 0;
      row_pos++;
      if (row_pos >= frame_h) row_pos = 0;
    end
  endtask

  task automatic send_pixel(input cde_pkg::pix_t p);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= p;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_edge(p);
  endtask

  task automatic wait_drained;
    in_valid <= 1'b0;
    while (expected_edges.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic [3:0] addr, input logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (addr)
      REG_THRESHOLD: edge_thr = int'(val[8:0]);
      REG_MONO:      edge_mono = int'(val[0]);
      REG_WIDTH: begin
        frame_w = int'(val[11:0]);
        if (frame_w < cde_pkg::SIZE_MIN) frame_w = cde_pkg::SIZE_MIN;
        else if (frame_w > cde_pkg::MAX_WIDTH) frame_w = cde_pkg::MAX_WIDTH;
        col_pos = 0;
        row_pos = 0;
      end
      REG_HEIGHT: begin
        frame_h = int'(val[12:0]);
        if (frame_h < cde_pkg::SIZE_MIN) frame_h = cde_pkg::SIZE_MIN;
        else if (frame_h > cde_pkg::MAX_HEIGHT) frame_h = cde_pkg::MAX_HEIGHT;
        col_pos = 0;
        row_pos = 0;
      end
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic check_reg(input logic [3:0] addr, input logic [31:0] want, input string name);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= addr;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata !== want) report_mismatch(name, prdata, want);
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  always @(posedge clk) begin : result_check
    cde_pkg::res_t want;
    string         where;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_edges.size() == 0) begin
        report_mismatch("unexpected result", 1, 0);
      end else begin
        want = expected_edges.pop_front();
        where = $sformatf("(col %0d row %0d)", want.center_col, want.center_row);
        if (out_data.center_col !== want.center_col)
          report_mismatch({"center_col ", where}, 32'(out_data.center_col),
                          32'(want.center_col));
        if (out_data.center_row !== want.center_row)
          report_mismatch({"center_row ", where}, 32'(out_data.center_row),
                          32'(want.center_row));
        if (out_data.is_marked !== want.is_marked)
          report_mismatch({"is_marked ", where}, 32'(out_data.is_marked),
                          32'(want.is_marked));
        if (out_data.out_alpha !== want.out_alpha)
          report_mismatch({"out_alpha ", where}, 32'(out_data.out_alpha),
                          32'(want.out_alpha));
        if (out_data.out_red !== want.out_red)
          report_mismatch({"out_red ", where}, 32'(out_data.out_red), 32'(want.out_red));
        if (out_data.out_green !== want.out_green)
          report_mismatch({"out_green ", where}, 32'(out_data.out_green),
                          32'(want.out_green));
        if (out_data.out_blue !== want.out_blue)
          report_mismatch({"out_blue ", where}, 32'(out_data.out_blue), 32'(want.out_blue));
        if (out_data.frame_done !== want.frame_done)
          report_mismatch({"frame_done ", where}, 32'(out_data.frame_done),
                          32'(want.frame_done));
      end
    end
  end

  always @(posedge clk) begin : recv_drive
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  task automatic test_reset_defaults;
    int k;
    check_reg(REG_THRESHOLD, 32'd0, "reset threshold");
    check_reg(REG_MONO, 32'd0, "reset mono");
    check_reg(REG_WIDTH, 32'd640, "reset width");
    check_reg(REG_HEIGHT, 32'd480, "reset height");
    for (k = 0; k < 40; k++) send_pixel($urandom);
    wait_drained();
  endtask

  task automatic test_directed;
    cde_pkg::pix_t pattern [16];
    cde_pkg::pix_t small_frame [9];
    int   k;
    pattern = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF,
                32'h7F10_2030, 32'h7F10_2030, 32'h7F10_2031, 32'h00FF_0000,
                32'h7F10_2030, 32'h7F10_2030, 32'h7F10_2030, 32'h0000_FF00,
                32'h0000_00FF, 32'h8080_8080, 32'h7F10_2030, 32'hFFFF_FFFF};
    small_frame = '{32'hFFFF_FFFF, 32'h00FF_FFFF, 32'hFF00_0000,
                    32'h0000_0000, 32'h1234_5678, 32'hFFFF_FFFF,
                    32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000};
    write_reg(REG_THRESHOLD, 1);
    write_reg(REG_MONO, 0);
    write_reg(REG_WIDTH, 4);
    write_reg(REG_HEIGHT, 4);
    check_reg(REG_WIDTH, 32'd4, "width readback");
    for (k = 0; k < 16; k++) send_pixel(pattern[k]);
    wait_drained();
    write_reg(REG_THRESHOLD, 0);
    write_reg(REG_MONO, 1);
    write_reg(REG_WIDTH, 3);
    write_reg(REG_HEIGHT, 3);
    for (k = 0; k < 9; k++) send_pixel(small_frame[k]);
    wait_drained();
  endtask

  task automatic test_size_clamp_low;
    int v, k;
    write_reg(REG_THRESHOLD, 100);
    write_reg(REG_MONO, 0);
    for (v = 0; v < cde_pkg::SIZE_MIN; v++) begin
      write_reg(REG_WIDTH, v);
      write_reg(REG_HEIGHT, v);
      for (k = 0; k < 18; k++) send_pixel($urandom);
      wait_drained();
    end
  endtask

  task automatic test_frame_restart;
    int k;
    write_reg(REG_THRESHOLD, 60);
    write_reg(REG_MONO, 0);
    write_reg(REG_WIDTH, 9);
    write_reg(REG_HEIGHT, 6);
    for (k = 0; k < 31; k++) send_pixel($urandom);
    wait_drained();
    write_reg(REG_HEIGHT, 6);
    for (k = 0; k < 9 * 6 + 20; k++) send_pixel($urandom);
    wait_drained();
    write_reg(REG_WIDTH, 9);
    for (k = 0; k < 9 * 6; k++) send_pixel($urandom);
    wait_drained();
  endtask

  task automatic test_backpressure;
    int k;
    write_reg(REG_THRESHOLD, 40);
    write_reg(REG_MONO, 0);
    write_reg(REG_WIDTH, 16);
    write_reg(REG_HEIGHT, 8);
    hold_left = 300;
    for (k = 0; k < 128; k++) send_pixel($urandom);
    wait_drained();
  endtask

  task automatic test_random_frames(input int budget);
    int   sent, w, h, n, style, thr, k;
    cde_pkg::pix_t base, alt, near, p;
    sent = 0;
    while (sent < budget) begin
      w = ($urandom_range(9) == 0) ? $urandom_range(17, 64) : $urandom_range(3, 16);
      h = $urandom_range(3, 8);
      case ($urandom_range(9))
        0:       thr = 0;
        1:       thr = 511;
        2:       thr = 441;
        3:       thr = 442;
        4, 5, 6: thr = $urandom_range(1, 255);
        default: thr = $urandom_range(0, 511);
      endcase
      write_reg(REG_THRESHOLD, thr);
      write_reg(REG_MONO, $urandom_range(1));
      write_reg(REG_WIDTH, w);
      write_reg(REG_HEIGHT, h);
      n = w * h;
      case ($urandom_range(9))
        0:       n = $urandom_range(1, n - 1);
        1:       n = 2 * n + $urandom_range(0, w);
        default: ;
      endcase
      style = $urandom_range(3);
      if (style == 2 && thr > 255) style = 1;
      base = $urandom;
      alt = $urandom;
      near = base;
      if (style == 2) begin
        base.pix_red = 8'($urandom_range(0, 255 - thr));
        alt = base;
        alt.pix_red = 8'(base.pix_red + thr);
        alt.pix_alpha = 8'($urandom);
        near = base;
        near.pix_red = (thr == 0) ? base.pix_red : 8'(base.pix_red + thr - 1);
      end
      for (k = 0; k < n; k++) begin
        case (style)
          0: p = $urandom;
          1: p = $urandom_range(1) ? base : alt;
          2: begin
            case ($urandom_range(2))
              0:       p = base;
              1:       p = alt;
              default: p = near;
            endcase
          end
          default: begin
            p = $urandom_range(1) ? 32'h0000_0000 : 32'hFFFF_FFFF;
            p.pix_alpha = 8'($urandom);
          end
        endcase
        send_pixel(p);
      end
      sent += n;
      wait_drained();
    end
  endtask

  task automatic test_size_clamp_high;
    int k;
    write_reg(REG_THRESHOLD, 200);
    write_reg(REG_MONO, 0);
    write_reg(REG_WIDTH, 32'hFFFF_FFFF);
    write_reg(REG_HEIGHT, 3);
    check_reg(REG_WIDTH, 32'h0000_0FFF, "wide width readback");
    for (k = 0; k < 40; k++) send_pixel($urandom);
    wait_drained();
    write_reg(REG_MONO, 1);
    write_reg(REG_WIDTH, 3);
    write_reg(REG_HEIGHT, 32'h0000_1FFF);
    check_reg(REG_HEIGHT, 32'h0000_1FFF, "tall height readback");
    for (k = 0; k < 3 * 12 + 4; k++) send_pixel($urandom);
    wait_drained();
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    send_idle_pct = 30;
    recv_idle_pct = 51;
    test_reset_defaults();
    test_directed();
    test_size_clamp_low();
    send_idle_pct = 51;
    recv_idle_pct = 30;
    test_frame_restart();
    test_backpressure();
    test_random_frames(500);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_frames(500);
    test_size_clamp_high();
    wait_drained();
    if (mismatch_count == 0) begin
      $display("color_distance_edge_sketch_top regression: pass");
    end else begin
      $display("color_distance_edge_sketch_top regression: fail");
    end
    $finish;
  end

  initial begin
    #(64'd4_000_000);
    $display("color_distance_edge_sketch_top regression: fail");
    $finish;
  end

endmodule
